FILE: rtl/sdtq_pkg.sv
`timescale 1ns / 1ps

package sdtq_pkg;

   localparam int MODE_BITS   = 2;
   localparam int HID_BITS    = 8;
   localparam int DELAY_BITS  = 32;
   localparam int PERIOD_BITS = 32;
   localparam int NOW_BITS    = 48;
   localparam int OCC_BITS    = 5;
   localparam int REQ_DATA_BITS = 128;
   localparam int RSP_DATA_BITS = 16;

   localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_POLL   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_FINISH = 2'd2;

   localparam logic [PERIOD_BITS-1:0] ONE_SHOT = 32'hFFFF_FFFF;

   // Operation broadcast to every cell in the chain
   typedef enum logic [1:0] {
      OP_HOLD,     // no change
      OP_INSERT,   // sorted insert of the key entry
      OP_POP,      // drop the top entry, shift toward the top
      OP_POP_INS   // drop the top entry and insert the key in the same cycle
   } op_type;

endpackage

FILE: rtl/sdtq_cell.sv
`timescale 1ns / 1ps

module sdtq_cell
   import sdtq_pkg::*;
#(
   parameter int TIME_BITS = 48,
   parameter int ID_BITS   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  op_type                 op,
   input  logic [TIME_BITS-1:0]   key_deadline,
   input  logic [PERIOD_BITS-1:0] key_period,
   input  logic [ID_BITS-1:0]     key_handler,
   // left neighbor (toward the top); the top cell sees left_valid = left_lt = 1
   input  logic                   left_valid,
   input  logic                   left_lt,
   input  logic [TIME_BITS-1:0]   left_deadline,
   input  logic [PERIOD_BITS-1:0] left_period,
   input  logic [ID_BITS-1:0]     left_handler,
   // right neighbor (toward the tail); the last cell sees an empty entry
   input  logic                   right_valid,
   input  logic [TIME_BITS-1:0]   right_deadline,
   input  logic [PERIOD_BITS-1:0] right_period,
   input  logic [ID_BITS-1:0]     right_handler,
   output logic                   valid,
   output logic                   lt,
   output logic [TIME_BITS-1:0]   deadline,
   output logic [PERIOD_BITS-1:0] period,
   output logic [ID_BITS-1:0]     handler
);

   logic                   valid_ff, valid_in;
   logic [TIME_BITS-1:0]   deadline_ff, deadline_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [ID_BITS-1:0]     handler_ff, handler_in;

   // Entry ahead of the new key, judged on the contents this cell holds
   // after the pop when the top is being removed.
   always_comb begin
      unique case (op)
         OP_POP_INS: lt = right_valid && (right_deadline < key_deadline);
         default:    lt = valid_ff && (deadline_ff < key_deadline);
      endcase
   end

   always_comb begin
      valid_in    = valid_ff;
      deadline_in = deadline_ff;
      period_in   = period_ff;
      handler_in  = handler_ff;
      unique case (op)
         OP_HOLD: begin
         end
         OP_INSERT: begin
            valid_in = valid_ff | left_valid;
            if (lt) begin
            end else if (left_lt) begin
               deadline_in = key_deadline;
               period_in   = key_period;
               handler_in  = key_handler;
            end else begin
               deadline_in = left_deadline;
               period_in   = left_period;
               handler_in  = left_handler;
            end
         end
         OP_POP: begin
            valid_in    = right_valid;
            deadline_in = right_deadline;
            period_in   = right_period;
            handler_in  = right_handler;
         end
         OP_POP_INS: begin
            if (lt) begin
               deadline_in = right_deadline;
               period_in   = right_period;
               handler_in  = right_handler;
            end else if (left_lt) begin
               deadline_in = key_deadline;
               period_in   = key_period;
               handler_in  = key_handler;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      deadline_ff <= deadline_in;
      period_ff   <= period_in;
      handler_ff  <= handler_in;
   end

   assign valid    = valid_ff;
   assign deadline = deadline_ff;
   assign period   = period_ff;
   assign handler  = handler_ff;

endmodule

FILE: rtl/sorted_deadline_timer_queue.sv
`timescale 1ns / 1ps
// Channel   Dir  Ports                          Contents
// req       in   req_tvalid/tready/tdata/tuser  one add, poll or finish command
// rsp       out  rsp_tvalid/tready/tdata        due flag, handler, drop flag, occupancy
//
// One transaction per cycle: every command is applied to the whole cell chain in the
// cycle it is accepted, and its response is loaded into the output register then.
// A finish with rearm set on a periodic entry pops and re-inserts in that same single cycle.
// Reset clears the valid bit of every cell and the entry count; no clearing pass.
// A stalled response holds the output register; req_tready drops only while a
// response waits and rsp_tready is low.

module sorted_deadline_timer_queue
   import sdtq_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int ID_BITS   = 8,
   parameter int TIME_BITS = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // handler_id[7:0], delay[39:8], period[71:40], rearm[72], now[120:73], zeros
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // mode[1:0]
   input  logic [MODE_BITS-1:0]     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // due[0], due_handler[8:1], dropped[9], occupancy[14:10], zeros
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   logic [MODE_BITS-1:0]   mode;
   logic [HID_BITS-1:0]    in_handler;
   logic [DELAY_BITS-1:0]  in_delay;
   logic [PERIOD_BITS-1:0] in_period;
   logic                   in_more;
   logic [NOW_BITS-1:0]    in_now;
   logic [TIME_BITS-1:0]   now_t;

   assign mode       = req_tuser;
   assign in_handler = req_tdata[7:0];
   assign in_delay   = req_tdata[39:8];
   assign in_period  = req_tdata[71:40];
   assign in_more    = req_tdata[72];
   assign in_now     = req_tdata[120:73];
   assign now_t      = TIME_BITS'(in_now);

   logic                   accept;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   due_ff, due_in;
   logic [HID_BITS-1:0]    due_handler_ff, due_handler_in;
   logic                   dropped_ff, dropped_in;

   logic [DEPTH-1:0]       cell_valid;
   logic [DEPTH-1:0]       cell_lt;
   logic [TIME_BITS-1:0]   cell_deadline [DEPTH];
   logic [PERIOD_BITS-1:0] cell_period [DEPTH];
   logic [ID_BITS-1:0]     cell_handler [DEPTH];

   op_type                 op;
   logic [TIME_BITS-1:0]   key_deadline;
   logic [PERIOD_BITS-1:0] key_period;
   logic [ID_BITS-1:0]     key_handler;

   logic [TIME_BITS:0]     add_sum;
   logic [TIME_BITS:0]     renew_sum;
   logic [TIME_BITS-1:0]   add_deadline;
   logic [TIME_BITS-1:0]   renew_deadline;
   logic                   full;
   logic                   empty;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_FULL);
   assign empty      = (count_ff == '0);

   // Saturating deadline arithmetic
   assign add_sum        = {1'b0, now_t} + (TIME_BITS + 1)'(in_delay);
   assign renew_sum      = {1'b0, cell_deadline[0]} + (TIME_BITS + 1)'(cell_period[0]);
   assign add_deadline   = add_sum[TIME_BITS] ? TIME_MAX : add_sum[TIME_BITS-1:0];
   assign renew_deadline = renew_sum[TIME_BITS] ? TIME_MAX : renew_sum[TIME_BITS-1:0];

   always_comb begin
      op             = OP_HOLD;
      key_deadline   = add_deadline;
      key_period     = in_period;
      key_handler    = ID_BITS'(in_handler);
      count_in       = count_ff;
      due_in         = 1'b0;
      due_handler_in = '0;
      dropped_in     = 1'b0;
      if (accept) begin
         priority if (mode == MODE_ADD) begin
            op         = OP_INSERT;
            dropped_in = full;
            if (!full) begin
               count_in = count_ff + 1'b1;
            end
         end else if (mode == MODE_POLL) begin
            if (!empty && (cell_deadline[0] <= now_t)) begin
               due_in         = 1'b1;
               due_handler_in = HID_BITS'(cell_handler[0]);
            end
         end else if (mode == MODE_FINISH) begin
            if (!empty) begin
               key_deadline = renew_deadline;
               key_period   = cell_period[0];
               key_handler  = cell_handler[0];
               if (in_more && (cell_period[0] != ONE_SHOT)) begin
                  op = OP_POP_INS;
               end else begin
                  op       = OP_POP;
                  count_in = count_ff - 1'b1;
               end
            end
         end else begin
         end
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                   l_valid, l_lt, r_valid;
      logic [TIME_BITS-1:0]   l_deadline, r_deadline;
      logic [PERIOD_BITS-1:0] l_period, r_period;
      logic [ID_BITS-1:0]     l_handler, r_handler;

      if (i == 0) begin : g_top
         assign l_valid    = 1'b1;
         assign l_lt       = 1'b1;
         assign l_deadline = '0;
         assign l_period   = '0;
         assign l_handler  = '0;
      end else begin : g_mid
         assign l_valid    = cell_valid[i-1];
         assign l_lt       = cell_lt[i-1];
         assign l_deadline = cell_deadline[i-1];
         assign l_period   = cell_period[i-1];
         assign l_handler  = cell_handler[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign r_valid    = 1'b0;
         assign r_deadline = '0;
         assign r_period   = '0;
         assign r_handler  = '0;
      end else begin : g_body
         assign r_valid    = cell_valid[i+1];
         assign r_deadline = cell_deadline[i+1];
         assign r_period   = cell_period[i+1];
         assign r_handler  = cell_handler[i+1];
      end

      sdtq_cell #(
         .TIME_BITS (TIME_BITS),
         .ID_BITS   (ID_BITS)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .op             (op),
         .key_deadline   (key_deadline),
         .key_period     (key_period),
         .key_handler    (key_handler),
         .left_valid     (l_valid),
         .left_lt        (l_lt),
         .left_deadline  (l_deadline),
         .left_period    (l_period),
         .left_handler   (l_handler),
         .right_valid    (r_valid),
         .right_deadline (r_deadline),
         .right_period   (r_period),
         .right_handler  (r_handler),
         .valid          (cell_valid[i]),
         .lt             (cell_lt[i]),
         .deadline       (cell_deadline[i]),
         .period         (cell_period[i]),
         .handler        (cell_handler[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         due_ff         <= due_in;
         due_handler_ff <= due_handler_in;
         dropped_ff     <= dropped_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, OCC_BITS'(count_ff), dropped_ff, due_handler_ff, due_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count above depth");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("entry count disagrees with cell valid bits");

   a_top_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_valid[1] |-> (cell_deadline[0] <= cell_deadline[1]))
      else $error("top two entries out of order");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (mode == MODE_ADD) && !full) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("add on non-full queue did not grow it");

endmodule
